// ===== rtl/prax_pkg.sv =====
// ----------------------------------------------------------------------------
// prax_pkg
// Shared types and constants for the prefixed register ALU execute block.
// ----------------------------------------------------------------------------
package prax_pkg;

  localparam int unsigned WordW = 16;
  localparam int unsigned NumRegs = 15;
  localparam int unsigned RegIdxW = 4;
  localparam logic [RegIdxW-1:0] PcIdx = 4'd15;

  typedef struct packed {
    logic ov;
    logic s;
    logic cy;
    logic z;
  } flags_t;

  typedef struct packed {
    logic alt2;
    logic alt1;
    logic b;
  } prefix_t;

  typedef struct packed {
    logic             reg_write;
    logic [3:0]       reg_index;
    logic [WordW-1:0] reg_value;
    logic             low_write;
    logic [WordW-1:0] low_value;
    logic             pc_write;
    logic [WordW-1:0] new_pc;
    flags_t           flags;
    logic             unhandled;
  } result_t;

  function automatic logic [WordW-1:0] sext8(input logic [7:0] v);
    sext8 = {{8{v[7]}}, v};
  endfunction

endpackage

// ===== rtl/prax_core.sv =====
// ----------------------------------------------------------------------------
// prax_core
// Register file, flags and prefix state with the single-pass execute logic.
// ----------------------------------------------------------------------------
module prax_core import prax_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] opcode,
  input  logic [15:0] imm_word,
  input  logic [7:0] rom_byte,
  input  logic [15:0] pc,
  output result_t    res
);

  logic [WordW-1:0] regs [NumRegs];
  flags_t  flags;
  prefix_t prefix;
  logic [3:0] src_sel, dst_sel;

  flags_t  flags_next;
  prefix_t prefix_next;
  logic [3:0] src_sel_next, dst_sel_next;
  logic [WordW-1:0] regs_next [NumRegs];

  always_comb begin
    logic [3:0] n;
    logic [15:0] src, rn, m, v;
    logic [16:0] sum;
    logic [16:0] dif;
    logic bw, take, clr;
    logic signed [31:0] prod;
    logic [15:0] prod8;
    logic [3:0] wi;
    logic we;
    logic [15:0] wv;
    n = opcode[3:0];
    src = (src_sel == PcIdx) ? pc : regs[src_sel];
    rn = (n == PcIdx) ? pc : regs[n];
    m = prefix.alt2 ? {12'd0, n} : rn;
    flags_next = flags;
    prefix_next = prefix;
    src_sel_next = src_sel;
    dst_sel_next = dst_sel;
    regs_next = regs;
    clr = 1'b1;
    we = 1'b0; wi = '0; wv = '0;
    sum = '0; dif = '0; bw = 1'b0; take = 1'b0; prod = '0; prod8 = '0; v = '0;
    res = '0;
    if (opcode == 8'h01) begin
    end else if (opcode == 8'h03) begin
      v = {1'b0, src[15:1]};
      we = 1'b1; wi = dst_sel; wv = v;
      flags_next.cy = src[0];
      flags_next.z = (v == 16'd0); flags_next.s = v[15];
    end else if (opcode == 8'h04) begin
      v = {src[14:0], flags.cy};
      we = 1'b1; wi = dst_sel; wv = v;
      flags_next.cy = src[15];
      flags_next.z = (v == 16'd0); flags_next.s = v[15];
    end else if (opcode inside {[8'h05:8'h0f]}) begin
      case (opcode[3:0])
        4'h5: take = 1'b1;
        4'h6: take = flags.s == flags.ov;
        4'h7: take = flags.s != flags.ov;
        4'h8: take = !flags.z;
        4'h9: take = flags.z;
        4'ha: take = !flags.s;
        4'hb: take = flags.s;
        4'hc: take = !flags.cy;
        4'hd: take = flags.cy;
        4'he: take = !flags.ov;
        default: take = flags.ov;
      endcase
      if (take) begin
        res.pc_write = 1'b1; res.new_pc = pc + sext8(imm_word[7:0]);
      end
      clr = 1'b0;
    end else if (opcode inside {[8'h10:8'h1f]}) begin
      if (!prefix.b) begin
        dst_sel_next = n; clr = 1'b0;
      end else begin
        we = 1'b1; wi = n; wv = src;
      end
    end else if (opcode inside {[8'h20:8'h2f]}) begin
      src_sel_next = n; dst_sel_next = n; prefix_next.b = 1'b1; clr = 1'b0;
    end else if (opcode == 8'h3c) begin
      v = regs[12] - 16'd1;
      we = 1'b1; wi = 4'd12; wv = v;
      flags_next.z = (v == 16'd0); flags_next.s = v[15];
      if (v != 16'd0) begin
        res.pc_write = 1'b1; res.new_pc = regs[13];
      end
    end else if (opcode inside {[8'h3d:8'h3f]}) begin
      prefix_next.b = 1'b0;
      if (opcode != 8'h3e) prefix_next.alt1 = 1'b1;
      if (opcode != 8'h3d) prefix_next.alt2 = 1'b1;
      clr = 1'b0;
    end else if (opcode == 8'h4d || opcode == 8'h4f) begin
      v = (opcode == 8'h4d) ? {src[7:0], src[15:8]} : ~src;
      we = 1'b1; wi = dst_sel; wv = v;
      flags_next.z = (v == 16'd0); flags_next.s = v[15];
    end else if (opcode inside {[8'h50:8'h5f]}) begin
      sum = {1'b0, src} + {1'b0, m} + {16'd0, prefix.alt1 & flags.cy};
      flags_next.ov = ~(src[15] ^ m[15]) & (m[15] ^ sum[15]);
      flags_next.cy = sum[16];
      v = sum[15:0];
      we = 1'b1; wi = dst_sel; wv = v;
      flags_next.z = (v == 16'd0); flags_next.s = v[15];
    end else if (opcode inside {[8'h60:8'h6f]}) begin
      m = (!prefix.alt2 || prefix.alt1) ? rn : {12'd0, n};
      bw = !prefix.alt2 && prefix.alt1 && !flags.cy;
      dif = {1'b0, src} - {1'b0, m} - {16'd0, bw};
      v = dif[15:0];
      flags_next.ov = (src[15] ^ m[15]) & (src[15] ^ v[15]);
      flags_next.cy = !dif[16];
      flags_next.z = (v == 16'd0); flags_next.s = v[15];
      if (!(prefix.alt1 && prefix.alt2)) begin
        we = 1'b1; wi = dst_sel; wv = v;
      end
    end else if (opcode == 8'h70) begin
      v = {regs[7][15:8], regs[8][15:8]};
      we = 1'b1; wi = dst_sel; wv = v;
      flags_next.ov = |(v & 16'hc0c0);
      flags_next.s = |(v & 16'h8080);
      flags_next.cy = |(v & 16'he0e0);
      flags_next.z = |(v & 16'hf0f0);
    end else if (opcode inside {[8'h71:8'h7f], [8'hc1:8'hcf]}) begin
      if (opcode[7:4] == 4'h7) v = src & (prefix.alt1 ? ~m : m);
      else v = prefix.alt1 ? (src ^ m) : (src | m);
      we = 1'b1; wi = dst_sel; wv = v;
      flags_next.z = (v == 16'd0); flags_next.s = v[15];
    end else if (opcode inside {[8'h80:8'h8f]}) begin
      if (!prefix.alt1) prod8 = 16'($signed(src[7:0]) * $signed(m[7:0]));
      else prod8 = src[7:0] * m[7:0];
      v = prod8;
      we = 1'b1; wi = dst_sel; wv = v;
      flags_next.z = (v == 16'd0); flags_next.s = v[15];
    end else if (opcode inside {[8'h91:8'h94]}) begin
      we = 1'b1; wi = 4'd11; wv = pc + {12'd0, n};
    end else if (opcode inside {8'h95, 8'h96, 8'h97}) begin
      if (opcode == 8'h95) v = sext8(src[7:0]);
      else if (opcode == 8'h96) begin
        v = {src[15], src[15:1]};
        if (prefix.alt1 && src == 16'hffff) v = '0;
        flags_next.cy = src[0];
      end else begin
        v = {flags.cy, src[15:1]};
        flags_next.cy = src[0];
      end
      we = 1'b1; wi = dst_sel; wv = v;
      flags_next.z = (v == 16'd0); flags_next.s = v[15];
    end else if (opcode inside {[8'h98:8'h9d]}) begin
      if (!prefix.alt1) begin
        res.pc_write = 1'b1; res.new_pc = rn;
      end else res.unhandled = 1'b1;
    end else if (opcode == 8'h9e || opcode == 8'hc0) begin
      v = (opcode == 8'h9e) ? {8'd0, src[7:0]} : {8'd0, src[15:8]};
      we = 1'b1; wi = dst_sel; wv = v;
      flags_next.s = v[7]; flags_next.z = (v == 16'd0);
    end else if (opcode == 8'h9f) begin
      prod = $signed(src) * $signed(regs[6]);
      if (prefix.alt1) begin
        regs_next[4] = prod[15:0];
        res.low_write = 1'b1; res.low_value = prod[15:0];
      end
      v = prod[31:16];
      we = 1'b1; wi = dst_sel; wv = v;
      flags_next.z = (v == 16'd0); flags_next.s = v[15];
      flags_next.cy = prod[15];
    end else if (opcode inside {[8'ha0:8'haf], [8'hf0:8'hff]}) begin
      if (prefix.alt1 || prefix.alt2) res.unhandled = 1'b1;
      else begin
        we = 1'b1; wi = n;
        wv = opcode[6] ? imm_word : sext8(imm_word[7:0]);
      end
    end else if (opcode inside {[8'hb0:8'hbf]}) begin
      if (!prefix.b) begin
        src_sel_next = n; clr = 1'b0;
      end else begin
        v = rn;
        we = 1'b1; wi = dst_sel; wv = v;
        flags_next.ov = v[7];
        flags_next.z = (v == 16'd0); flags_next.s = v[15];
      end
    end else if (opcode inside {[8'hd0:8'hde], [8'he0:8'hee]}) begin
      v = opcode[5] ? regs[n] - 16'd1 : regs[n] + 16'd1;
      we = 1'b1; wi = n; wv = v;
      flags_next.z = (v == 16'd0); flags_next.s = v[15];
    end else if (opcode == 8'hef) begin
      case ({prefix.alt2, prefix.alt1})
        2'b00: v = {8'd0, rom_byte};
        2'b01: v = {rom_byte, src[7:0]};
        2'b10: v = {src[15:8], rom_byte};
        default: v = sext8(rom_byte);
      endcase
      we = 1'b1; wi = dst_sel; wv = v;
    end else begin
      res.unhandled = 1'b1;
    end
    if (we) begin
      if (wi == PcIdx) begin
        res.pc_write = 1'b1; res.new_pc = wv;
      end else begin
        regs_next[wi] = wv;
        res.reg_write = 1'b1; res.reg_index = wi; res.reg_value = wv;
      end
    end
    if (clr) begin
      prefix_next = '0; src_sel_next = '0; dst_sel_next = '0;
    end
    res.flags = flags_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NumRegs; i++) regs[i] <= '0;
      flags <= '0;
      prefix <= '0;
      src_sel <= '0;
      dst_sel <= '0;
    end else if (step) begin
      regs <= regs_next;
      flags <= flags_next;
      prefix <= prefix_next;
      src_sel <= src_sel_next;
      dst_sel <= dst_sel_next;
    end
  end

`ifndef SYNTH
  a_clr_unh: assert property (@(posedge clk) disable iff (rst)
    step && res.unhandled |=> prefix == '0 && src_sel == '0 && dst_sel == '0)
    else $error("prefix kept after unhandled opcode");
  a_one_w: assert property (@(posedge clk) disable iff (rst)
    step && res.reg_write |-> res.reg_index != PcIdx)
    else $error("r15 written as general register");
  a_low: assert property (@(posedge clk) disable iff (rst)
    step && res.low_write |=> regs[4] == $past(res.low_value) ||
      $past(res.reg_index) == 4'd4)
    else $error("low product lost");
`endif

endmodule

// ===== rtl/prefixed_register_alu_execute.sv =====
// ----------------------------------------------------------------------------
// prefixed_register_alu_execute
// Execute stage for a 16-bit prefix-modified register machine.
// ----------------------------------------------------------------------------
// One instruction per cycle: a request is executed in the cycle it is
// accepted and its result sits in an output register; a new request is taken
// whenever that register is empty or being drained. Memory, plot, color,
// cache and stop opcodes raise unhandled and only clear the prefix state.
module prefixed_register_alu_execute import prax_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  opcode,
  input  logic [15:0] imm_word,
  input  logic [7:0]  rom_byte,
  input  logic [15:0] pc,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        reg_write,
  output logic [3:0]  reg_index,
  output logic [15:0] reg_value,
  output logic        low_write,
  output logic [15:0] low_value,
  output logic        pc_write,
  output logic [15:0] new_pc,
  output logic        zero_flag,
  output logic        carry_flag,
  output logic        sign_flag,
  output logic        overflow_flag,
  output logic        unhandled
);

  result_t res, res_q;
  logic step;

  assign in_ready = !out_valid || out_ready;
  assign step = in_valid && in_ready;

  prax_core u_core (
    .clk, .rst, .step, .opcode, .imm_word, .rom_byte, .pc, .res
  );

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (in_ready) out_valid <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (step) res_q <= res;
  end

  assign reg_write = res_q.reg_write;
  assign reg_index = res_q.reg_index;
  assign reg_value = res_q.reg_value;
  assign low_write = res_q.low_write;
  assign low_value = res_q.low_value;
  assign pc_write = res_q.pc_write;
  assign new_pc = res_q.new_pc;
  assign zero_flag = res_q.flags.z;
  assign carry_flag = res_q.flags.cy;
  assign sign_flag = res_q.flags.s;
  assign overflow_flag = res_q.flags.ov;
  assign unhandled = res_q.unhandled;

`ifndef SYNTH
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(res_q))
    else $error("result dropped while stalled");
  a_take: assert property (@(posedge clk) disable iff (rst)
    step |=> out_valid)
    else $error("accepted request produced no result");
  a_rdy: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("stalled while empty");
`endif

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for prefixed_register_alu_execute. Directed opcodes
// and extremes come first, then random prefix-plus-instruction sequences
// under three idle mixes, a long output stall and a drain pause. A software
// copy of the register file, flags and prefix state predicts each result.
// ----------------------------------------------------------------------------
module tb;
  import prax_pkg::*;

  class exec_scoreboard;
    logic [15:0] regs[15];
    flags_t      fl;
    prefix_t     pf;
    logic [3:0]  ssel, dsel;
    logic [15:0] cur_pc;
    result_t     r;
    result_t     expected_q[$];
    int          fails;

    function new();
      foreach (regs[i]) regs[i] = '0;
      fl = '0; pf = '0; ssel = '0; dsel = '0; fails = 0;
    endfunction

    function logic [15:0] rd(logic [3:0] n);
      return (n == PcIdx) ? cur_pc : regs[n];
    endfunction

    function void wr(logic [3:0] n, logic [15:0] v);
      if (n == PcIdx) begin
        r.pc_write = 1'b1; r.new_pc = v;
      end else begin
        regs[n] = v;
        r.reg_write = 1'b1; r.reg_index = n; r.reg_value = v;
      end
    endfunction

    function void setzs(logic [15:0] v);
      fl.z = (v == 16'h0);
      fl.s = v[15];
    endfunction

    function void dest_zs(logic [15:0] v);
      wr(dsel, v);
      setzs(v);
    endfunction

    function void note_request(logic [7:0] op, logic [15:0] imm, logic [7:0] rom,
                               logic [15:0] pcv);
      logic a1, a2, b, clr, take;
      logic [3:0] n;
      logic [15:0] src, v, m16, simm;
      logic [31:0] m, res, bw, p;
      int x, y;
      r = '0;
      cur_pc = pcv;
      a1 = pf.alt1; a2 = pf.alt2; b = pf.b;
      clr = 1'b1;
      n = op[3:0];
      src = rd(ssel);
      simm = {{8{imm[7]}}, imm[7:0]};
      m16 = a2 ? {12'h0, n} : rd(n);
      if (op == 8'h01) begin
      end else if (op == 8'h03) begin
        fl.cy = src[0];
        dest_zs(src >> 1);
      end else if (op == 8'h04) begin
        dest_zs({src[14:0], fl.cy});
        fl.cy = src[15];
      end else if (op >= 8'h05 && op <= 8'h0f) begin
        case (op)
          8'h05: take = 1'b1;
          8'h06: take = fl.s == fl.ov;
          8'h07: take = fl.s != fl.ov;
          8'h08: take = !fl.z;
          8'h09: take = fl.z;
          8'h0a: take = !fl.s;
          8'h0b: take = fl.s;
          8'h0c: take = !fl.cy;
          8'h0d: take = fl.cy;
          8'h0e: take = !fl.ov;
          default: take = fl.ov;
        endcase
        if (take) wr(PcIdx, pcv + simm);
        clr = 1'b0;
      end else if (op >= 8'h10 && op <= 8'h1f) begin
        if (!b) begin
          dsel = n; clr = 1'b0;
        end else begin
          wr(n, src);
        end
      end else if (op >= 8'h20 && op <= 8'h2f) begin
        ssel = n; dsel = n; pf.b = 1'b1; clr = 1'b0;
      end else if (op == 8'h3c) begin
        v = regs[12] - 16'd1;
        wr(4'd12, v);
        setzs(v);
        if (v != 0) wr(PcIdx, regs[13]);
      end else if (op >= 8'h3d && op <= 8'h3f) begin
        pf.b = 1'b0;
        if (op != 8'h3e) pf.alt1 = 1'b1;
        if (op != 8'h3d) pf.alt2 = 1'b1;
        clr = 1'b0;
      end else if (op == 8'h4d) begin
        dest_zs({src[7:0], src[15:8]});
      end else if (op == 8'h4f) begin
        dest_zs(~src);
      end else if (op >= 8'h50 && op <= 8'h5f) begin
        m = {16'h0, m16};
        res = {16'h0, src} + m + {31'h0, a1 & fl.cy};
        fl.ov = (~({16'h0, src} ^ m) & (m ^ res) & 32'h8000) != 0;
        fl.cy = res >= 32'h10000;
        dest_zs(res[15:0]);
      end else if (op >= 8'h60 && op <= 8'h6f) begin
        m = (!a2 || a1) ? {16'h0, rd(n)} : {28'h0, n};
        bw = {31'h0, !a2 && a1 && !fl.cy};
        res = {16'h0, src} - m - bw;
        fl.ov = (({16'h0, src} ^ m) & ({16'h0, src} ^ res) & 32'h8000) != 0;
        fl.cy = {16'h0, src} >= m + bw;
        setzs(res[15:0]);
        if (!(a1 && a2)) wr(dsel, res[15:0]);
      end else if (op == 8'h70) begin
        v = {regs[7][15:8], regs[8][15:8]};
        wr(dsel, v);
        fl.ov = (v & 16'hc0c0) != 0;
        fl.s = (v & 16'h8080) != 0;
        fl.cy = (v & 16'he0e0) != 0;
        fl.z = (v & 16'hf0f0) != 0;
      end else if (op >= 8'h71 && op <= 8'h7f) begin
        dest_zs(src & (a1 ? ~m16 : m16));
      end else if (op >= 8'h80 && op <= 8'h8f) begin
        if (!a1) begin
          x = $signed(src[7:0]); y = $signed(m16[7:0]);
          p = x * y;
          v = p[15:0];
        end else begin
          v = {8'h0, src[7:0]} * {8'h0, m16[7:0]};
        end
        dest_zs(v);
      end else if (op >= 8'h91 && op <= 8'h94) begin
        wr(4'd11, pcv + {12'h0, n});
      end else if (op == 8'h95) begin
        dest_zs({{8{src[7]}}, src[7:0]});
      end else if (op == 8'h96) begin
        fl.cy = src[0];
        v = {src[15], src[15:1]};
        if (a1 && src == 16'hffff) v = '0;
        dest_zs(v);
      end else if (op == 8'h97) begin
        dest_zs({fl.cy, src[15:1]});
        fl.cy = src[0];
      end else if (op >= 8'h98 && op <= 8'h9d) begin
        if (!a1) wr(PcIdx, rd(n));
        else r.unhandled = 1'b1;
      end else if (op == 8'h9e) begin
        v = {8'h0, src[7:0]};
        wr(dsel, v);
        fl.s = v[7]; fl.z = (v == 0);
      end else if (op == 8'h9f) begin
        x = $signed(src); y = $signed(regs[6]);
        p = x * y;
        if (a1) begin
          regs[4] = p[15:0];
          r.low_write = 1'b1; r.low_value = p[15:0];
        end
        dest_zs(p[31:16]);
        fl.cy = p[15];
      end else if (op >= 8'ha0 && op <= 8'haf) begin
        if (a1 || a2) r.unhandled = 1'b1;
        else wr(n, simm);
      end else if (op >= 8'hb0 && op <= 8'hbf) begin
        if (!b) begin
          ssel = n; clr = 1'b0;
        end else begin
          v = rd(n);
          wr(dsel, v);
          fl.ov = v[7];
          setzs(v);
        end
      end else if (op == 8'hc0) begin
        v = {8'h0, src[15:8]};
        wr(dsel, v);
        fl.s = v[7]; fl.z = (v == 0);
      end else if (op >= 8'hc1 && op <= 8'hcf) begin
        dest_zs(a1 ? (src ^ m16) : (src | m16));
      end else if (op >= 8'hd0 && op <= 8'hde) begin
        v = regs[n] + 16'd1;
        wr(n, v);
        setzs(v);
      end else if (op >= 8'he0 && op <= 8'hee) begin
        v = regs[n] - 16'd1;
        wr(n, v);
        setzs(v);
      end else if (op == 8'hef) begin
        if (!a1 && !a2) v = {8'h0, rom};
        else if (a1 && !a2) v = {rom, src[7:0]};
        else if (!a1) v = {src[15:8], rom};
        else v = {{8{rom[7]}}, rom};
        wr(dsel, v);
      end else if (op >= 8'hf0) begin
        if (a1 || a2) r.unhandled = 1'b1;
        else wr(n, imm);
      end else begin
        r.unhandled = 1'b1;
      end
      if (clr) begin
        pf = '0; ssel = '0; dsel = '0;
      end
      r.flags = fl;
      expected_q.push_back(r);
    endfunction

    function void cmp(string name, logic [15:0] e, logic [15:0] a);
      if (e !== a) begin
        $error("%s expected %h actual %h", name, e, a);
        fails++;
      end
    endfunction

    function void check_result(result_t got);
      result_t e;
      if (expected_q.size() == 0) begin
        $error("result with no request waiting");
        fails++;
        return;
      end
      e = expected_q.pop_front();
      cmp("reg_write", e.reg_write, got.reg_write);
      cmp("reg_index", e.reg_index, got.reg_index);
      cmp("reg_value", e.reg_value, got.reg_value);
      cmp("low_write", e.low_write, got.low_write);
      cmp("low_value", e.low_value, got.low_value);
      cmp("pc_write", e.pc_write, got.pc_write);
      cmp("new_pc", e.new_pc, got.new_pc);
      cmp("zero_flag", e.flags.z, got.flags.z);
      cmp("carry_flag", e.flags.cy, got.flags.cy);
      cmp("sign_flag", e.flags.s, got.flags.s);
      cmp("overflow_flag", e.flags.ov, got.flags.ov);
      cmp("unhandled", e.unhandled, got.unhandled);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  opcode = '0;
  logic [15:0] imm_word = '0;
  logic [7:0]  rom_byte = '0;
  logic [15:0] pc = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        reg_write, low_write, pc_write;
  logic [3:0]  reg_index;
  logic [15:0] reg_value, low_value, new_pc;
  logic        zero_flag, carry_flag, sign_flag, overflow_flag, unhandled;

  exec_scoreboard sb = new();
  int send_idle = 0;
  int recv_idle = 0;
  int hold_cycles = 0;

  prefixed_register_alu_execute dut (.*);

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) sb.note_request(opcode, imm_word, rom_byte, pc);
    if (!rst && out_valid && out_ready)
      sb.check_result('{reg_write, reg_index, reg_value, low_write, low_value,
                        pc_write, new_pc,
                        '{overflow_flag, sign_flag, carry_flag, zero_flag},
                        unhandled});
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  task automatic send(logic [7:0] op, logic [15:0] imm, logic [7:0] rom, logic [15:0] pcv);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op; imm_word <= imm; rom_byte <= rom; pc <= pcv;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_rand(logic [7:0] op);
    logic [15:0] pcv;
    pcv = ($urandom_range(9) == 0) ? {16{1'($urandom_range(1))}} : 16'($urandom);
    send(op, 16'($urandom), 8'($urandom), pcv);
  endtask

  // prefix chains followed by an instruction about half the time, else bare noise
  task automatic send_sequence(inout int count);
    int k;
    k = $urandom_range(99);
    if (k < 60) begin
      if ($urandom_range(1)) begin
        send_rand(8'h20 + 8'($urandom_range(15))); count++;
      end
      if ($urandom_range(2) == 0) begin
        send_rand(8'h3d + 8'($urandom_range(2))); count++;
      end
      if ($urandom_range(2) == 0) begin
        send_rand(($urandom_range(1) ? 8'h10 : 8'hb0) + 8'($urandom_range(15))); count++;
      end
    end
    send_rand(8'($urandom)); count++;
  endtask

  task automatic drain();
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    int count;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send(8'hf1, 16'hffff, 8'h00, 16'h0000);
    send(8'hf2, 16'h8000, 8'hff, 16'hffff);
    send(8'ha3, 16'h0080, 8'h00, 16'h0000);
    send(8'hf6, 16'h7fff, 8'h00, 16'h0000);
    send(8'h21, 16'h0000, 8'h00, 16'h0000);
    send(8'h52, 16'h0000, 8'h00, 16'h0000);
    send(8'h3d, 16'h0000, 8'h00, 16'h0000);
    send(8'h21, 16'h0000, 8'h00, 16'h0000);
    send(8'h61, 16'h0000, 8'h00, 16'h0000);
    send(8'h3f, 16'h0000, 8'h00, 16'h0000);
    send(8'h62, 16'h0000, 8'h00, 16'h0000);
    send(8'h0c, 16'h00ff, 8'h00, 16'h0000);
    send(8'h0d, 16'h007f, 8'h00, 16'hffff);
    send(8'h3d, 16'h0000, 8'h00, 16'h0000);
    send(8'h21, 16'h0000, 8'h00, 16'h0000);
    send(8'h9f, 16'h0000, 8'h00, 16'h0000);
    send(8'h3d, 16'h0000, 8'h00, 16'h0000);
    send(8'h96, 16'h0000, 8'h00, 16'h0000);
    send(8'h3c, 16'h0000, 8'h00, 16'h1234);
    send(8'hef, 16'h0000, 8'hff, 16'h0000);
    send(8'h3d, 16'h0000, 8'h00, 16'h0000);
    send(8'h98, 16'h0000, 8'h00, 16'h0000);
    send(8'h70, 16'h0000, 8'h00, 16'h0000);
    send(8'h00, 16'h0000, 8'h00, 16'h0000);
    send(8'h9b, 16'h0000, 8'h00, 16'hfffe);

    send_idle = 27; recv_idle = 72;
    count = 0;
    while (count < 350) send_sequence(count);
    send_idle = 72; recv_idle = 27;
    while (count < 700) send_sequence(count);
    send_idle = 0; recv_idle = 0;
    hold_cycles = 60;
    while (count < 740) send_sequence(count);
    in_valid <= 1'b0;
    drain();
    while (count < 1050) send_sequence(count);
    in_valid <= 1'b0;

    drain();
    repeat (5) @(posedge clk);
    if (sb.fails == 0 && sb.expected_q.size() == 0) begin
      $display("** prefixed_register_alu_execute: PASSED **");
    end else begin
      $display("** prefixed_register_alu_execute: FAILED **");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("** prefixed_register_alu_execute: FAILED **");
    $finish;
  end

endmodule
